FILE: rtl/closest_pair_of_points_top_defines.svh
// Assertion macros shared by the closest-pair block.
`ifndef CLOSEST_PAIR_OF_POINTS_TOP_DEFINES_SVH
`define CLOSEST_PAIR_OF_POINTS_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

FILE: rtl/cpp_pkg.sv
// Types and constants shared by the closest-pair block.
package cpp_pkg;

  localparam int COORD_W = 31;
  localparam int ID_W    = 10;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int DIST_W  = 63;

  // Squared distance reported when the set holds no pair.
  localparam logic [DIST_W-1:0] DIST_NONE = '1;

  // One stored point, coordinates in offset binary so unsigned order matches signed order.
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [ID_W-1:0]    id;
  } point_t;

  // Request from the sequencer to the distance unit.
  typedef struct packed {
    logic   start;
    point_t a;
    point_t b;
  } dist_req_t;

  // Result from the distance unit, identifiers already ordered.
  typedef struct packed {
    logic              done;
    logic [DIST_W-1:0] sq_dist;
    logic [ID_W-1:0]   lo;
    logic [ID_W-1:0]   hi;
  } dist_res_t;

endpackage

FILE: rtl/closest_pair_of_points_top.sv
// Top level of the closest-pair block: load sequencer, pair scan and result register.
//
// Usage: points arrive on the input channel (in_valid / in_stall), one transaction
// per point with x_coord, y_coord, point_id and last_point. While loading, the block
// takes one point every cycle and writes it into the point store; points beyond
// MAX_POINTS are dropped, but a dropped closing point still ends the set.
// After the transaction with last_point set, in_stall stays high while the pair scan
// runs. The scan reads point i once, then each partner j through the store's
// registered read port and the shared multiplier of the distance unit, one pair
// at a time, and goes on to the next point i after its last partner.
// One result transaction follows (min_dist_sq, first_id, second_id, found). The
// result sits in an output register, so loading of the next set resumes at once
// while the receiver holds out_stall; a later scan waits at its end until the
// previous result is taken. With fewer than two points, found is 0, the distance
// is all ones and both identifiers are 0.
// Reset (rst, synchronous) empties the store, returns to loading and drops any
// pending result. Store contents need no clearing: only written entries are read.
`include "closest_pair_of_points_top_defines.svh"

module closest_pair_of_points_top #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [30:0]          x_coord,
  input  logic signed [30:0]          y_coord,
  input  logic [9:0]                  point_id,
  input  logic                        last_point,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [62:0]                 min_dist_sq,
  output logic [9:0]                  first_id,
  output logic [9:0]                  second_id,
  output logic                        found
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [7:0] {
    S_LOAD  = 8'b00000001,
    S_START = 8'b00000010,
    S_RD_I  = 8'b00000100,
    S_LAT_I = 8'b00001000,
    S_RD_J  = 8'b00010000,
    S_GO    = 8'b00100000,
    S_WAIT  = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [CW-1:0]       i;
  logic [CW-1:0]       i_next;
  logic [CW-1:0]       j;
  logic [CW-1:0]       j_next;

  logic                in_accept;
  logic                wr_en;
  cpp_pkg::point_t     wr_point;
  logic [AW-1:0]       rd_addr;
  cpp_pkg::point_t     rd_point;
  cpp_pkg::point_t     pi;
  cpp_pkg::dist_req_t  dreq;
  cpp_pkg::dist_res_t  dres;
  logic                out_free;
  logic                better;

  logic [cpp_pkg::DIST_W-1:0] best_dist;
  logic [cpp_pkg::ID_W-1:0]   best_lo;
  logic [cpp_pkg::ID_W-1:0]   best_hi;

  assign in_stall  = (state != S_LOAD);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Convert coordinates to offset binary on the way into the store.
  assign wr_en       = in_accept && (count < CW'(MAX_POINTS));
  assign wr_point.x  = {~x_coord[30], x_coord[29:0]};
  assign wr_point.y  = {~y_coord[30], y_coord[29:0]};
  assign wr_point.id = point_id;

  assign rd_addr = (state == S_RD_I) ? i[AW-1:0] : j[AW-1:0];

  cpp_store #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[AW-1:0]),
    .wr_data (wr_point),
    .rd_addr (rd_addr),
    .rd_data (rd_point)
  );

  // Pair request: point i is held, partner j comes straight from the read port.
  assign dreq.start = (state == S_GO);
  assign dreq.a     = pi;
  assign dreq.b     = rd_point;

  cpp_dist_unit u_dist (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .res (dres)
  );

  // A pair wins on smaller distance, then on the smaller (low, high) identifier pair.
  assign better = (dres.sq_dist < best_dist) ||
                  ((dres.sq_dist == best_dist) &&
                   ((dres.lo < best_lo) || ((dres.lo == best_lo) && (dres.hi < best_hi))));

  // Sequencer: load points, then walk all pairs i < j.
  always_comb begin
    state_next = state;
    count_next = count;
    i_next     = i;
    j_next     = j;
    unique case (state)
      S_LOAD: begin
        if (in_accept) begin
          if (count < CW'(MAX_POINTS)) begin
            count_next = count + CW'(1);
          end
          if (last_point) begin
            state_next = S_START;
          end
        end
      end
      S_START: begin
        i_next     = '0;
        state_next = (count < CW'(2)) ? S_DONE : S_RD_I;
      end
      S_RD_I: begin
        state_next = S_LAT_I;
      end
      S_LAT_I: begin
        j_next     = i + CW'(1);
        state_next = S_RD_J;
      end
      S_RD_J: begin
        state_next = S_GO;
      end
      S_GO: begin
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (dres.done) begin
          if ((j + CW'(1)) < count) begin
            j_next     = j + CW'(1);
            state_next = S_RD_J;
          end else if ((i + CW'(2)) < count) begin
            i_next     = i + CW'(1);
            state_next = S_RD_I;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          count_next = '0;
          state_next = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      priority if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Scan indexes, held point, running best and the result register.
  always_ff @(posedge clk) begin
    i <= i_next;
    j <= j_next;
    if (state == S_LAT_I) begin
      pi <= rd_point;
    end
    if (state == S_START) begin
      best_dist <= cpp_pkg::DIST_NONE;
      best_lo   <= '0;
      best_hi   <= '0;
    end else if (state == S_WAIT && dres.done && better) begin
      best_dist <= dres.sq_dist;
      best_lo   <= dres.lo;
      best_hi   <= dres.hi;
    end
    if (state == S_DONE && out_free) begin
      min_dist_sq <= best_dist;
      first_id    <= best_lo;
      second_id   <= best_hi;
      found       <= (count >= CW'(2));
    end
  end

  // The fill count never passes the store depth.
  `ASSERT_PROP(a_count_bound, clk, rst, count <= CW'(MAX_POINTS))
  // Each pair started has its partner after the held point and inside the set.
  `ASSERT_PROP(a_pair_order, clk, rst, (state == S_GO) |-> (j > i && j < count))
  // The distance unit only reports while the sequencer waits for it.
  `ASSERT_NEVER(a_done_unexpected, clk, rst, dres.done && (state != S_WAIT))
  // A reported pair always lists the lower identifier first.
  `ASSERT_PROP(a_id_order, clk, rst, (out_valid && found) |-> (first_id <= second_id))

endmodule

FILE: rtl/cpp_store.sv
// Point store: one write port for loading, one registered read port for the pair scan.
module cpp_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  cpp_pkg::point_t wr_data,
  input  logic [AW-1:0]   rd_addr,
  output cpp_pkg::point_t rd_data
);

  cpp_pkg::point_t mem [DEPTH];

  // Write when loading; read data is registered and appears in the cycle after the address.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/cpp_dist_unit.sv
// Squared-distance unit: one shared 31x31 multiplier squares dx and then dy.
module cpp_dist_unit (
  input  logic                clk,
  input  logic                rst,
  input  cpp_pkg::dist_req_t  req,
  output cpp_pkg::dist_res_t  res
);

  typedef enum logic [3:0] {
    P_IDLE = 4'b0001,
    P_SQX  = 4'b0010,
    P_SQY  = 4'b0100,
    P_SUM  = 4'b1000
  } phase_t;

  phase_t phase;
  phase_t phase_next;

  logic [cpp_pkg::COORD_W-1:0] dx;
  logic [cpp_pkg::COORD_W-1:0] dy;
  logic [cpp_pkg::SQ_W-1:0]    sqx;
  logic [cpp_pkg::SQ_W-1:0]    sqy;
  logic [cpp_pkg::COORD_W-1:0] mul_op;
  logic [cpp_pkg::SQ_W-1:0]    prod;

  // Phase sequence: capture differences, square dx, square dy, add.
  always_comb begin
    unique case (phase)
      P_IDLE:  phase_next = req.start ? P_SQX : P_IDLE;
      P_SQX:   phase_next = P_SQY;
      P_SQY:   phase_next = P_SUM;
      P_SUM:   phase_next = P_IDLE;
      default: phase_next = P_IDLE;
    endcase
  end

  // The shared multiplier takes dx in the first square phase and dy in the second.
  assign mul_op = (phase == P_SQX) ? dx : dy;
  assign prod   = cpp_pkg::SQ_W'(mul_op) * cpp_pkg::SQ_W'(mul_op);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= P_IDLE;
      res.done <= 1'b0;
    end else begin
      phase    <= phase_next;
      res.done <= (phase == P_SUM);
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk) begin
    if (phase == P_IDLE && req.start) begin
      dx <= (req.a.x > req.b.x) ? req.a.x - req.b.x : req.b.x - req.a.x;
      dy <= (req.a.y > req.b.y) ? req.a.y - req.b.y : req.b.y - req.a.y;
      if (req.a.id < req.b.id) begin
        res.lo <= req.a.id;
        res.hi <= req.b.id;
      end else begin
        res.lo <= req.b.id;
        res.hi <= req.a.id;
      end
    end
    if (phase == P_SQX) begin
      sqx <= prod;
    end
    if (phase == P_SQY) begin
      sqy <= prod;
    end
    if (phase == P_SUM) begin
      res.sq_dist <= cpp_pkg::DIST_W'(sqx) + cpp_pkg::DIST_W'(sqy);
    end
  end

endmodule

FILE: test/closest_pair_monitor.sv
// Monitor for the closest-pair block: predicts each point set's result and checks the output.
module closest_pair_monitor #(
  parameter int DEPTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic signed [cpp_pkg::COORD_W-1:0] x_coord,
  input  logic signed [cpp_pkg::COORD_W-1:0] y_coord,
  input  logic [cpp_pkg::ID_W-1:0]           point_id,
  input  logic                               last_point,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [cpp_pkg::DIST_W-1:0]         min_dist_sq,
  input  logic [cpp_pkg::ID_W-1:0]           first_id,
  input  logic [cpp_pkg::ID_W-1:0]           second_id,
  input  logic                               found,
  output int                                 mismatch_count,
  output int                                 open_results
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [cpp_pkg::DIST_W-1:0] dist_sq;
    logic [cpp_pkg::ID_W-1:0]   low_id;
    logic [cpp_pkg::ID_W-1:0]   high_id;
    logic                       found;
  } pair_result_t;

  // Points of the set being loaded; entries past DEPTH are dropped like the block does.
  logic signed [cpp_pkg::COORD_W-1:0] set_x [DEPTH];
  logic signed [cpp_pkg::COORD_W-1:0] set_y [DEPTH];
  logic [cpp_pkg::ID_W-1:0]           set_id [DEPTH];
  int                                 set_size = 0;
  pair_result_t                       closest_q [$];
  int                                 errors = 0;

  // Squared Euclidean distance between two stored points.
  function automatic logic [cpp_pkg::DIST_W-1:0] squared_distance(input int a, input int b);
    logic signed [cpp_pkg::COORD_W:0] dx;
    logic signed [cpp_pkg::COORD_W:0] dy;
    logic [cpp_pkg::DIST_W-1:0]       mx;
    logic [cpp_pkg::DIST_W-1:0]       my;
    dx = (cpp_pkg::COORD_W+1)'(set_x[a]) - (cpp_pkg::COORD_W+1)'(set_x[b]);
    dy = (cpp_pkg::COORD_W+1)'(set_y[a]) - (cpp_pkg::COORD_W+1)'(set_y[b]);
    mx = cpp_pkg::DIST_W'((dx < 0) ? -dx : dx);
    my = cpp_pkg::DIST_W'((dy < 0) ? -dy : dy);
    return mx * mx + my * my;
  endfunction

  // Exhaustive pair search; ties resolve to the smallest (low id, high id) pair.
  function automatic pair_result_t closest_in_set();
    pair_result_t               best;
    logic [cpp_pkg::DIST_W-1:0] d;
    logic [cpp_pkg::ID_W-1:0]   lo;
    logic [cpp_pkg::ID_W-1:0]   hi;
    best.dist_sq = cpp_pkg::DIST_NONE;
    best.low_id  = '0;
    best.high_id = '0;
    best.found   = (set_size >= 2);
    for (int i = 0; i < set_size; i++) begin
      for (int j = i + 1; j < set_size; j++) begin
        d  = squared_distance(i, j);
        lo = (set_id[i] < set_id[j]) ? set_id[i] : set_id[j];
        hi = (set_id[i] < set_id[j]) ? set_id[j] : set_id[i];
        if (d < best.dist_sq || (d == best.dist_sq && {lo, hi} < {best.low_id, best.high_id}))
        begin
          best.dist_sq = d;
          best.low_id  = lo;
          best.high_id = hi;
        end
      end
    end
    return best;
  endfunction

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      errors++;
    end
  endtask

  // Both channels are sampled at the rising edge; a transaction is valid high with stall low.
  always @(posedge clk) begin
    pair_result_t want;
    if (rst) begin
      set_size = 0;
      closest_q.delete();
    end else begin
      // Result side: compare against the oldest pending set.
      if (out_valid && !out_stall) begin
        if (closest_q.size() == 0) begin
          $display("%0t ns: result with none expected, dist %0d ids %0d/%0d found %0d",
                   $time, min_dist_sq, first_id, second_id, found);
          errors++;
        end else begin
          want = closest_q.pop_front();
          check_field("min_dist_sq", 64'(want.dist_sq), 64'(min_dist_sq));
          check_field("first_id", 64'(want.low_id), 64'(first_id));
          check_field("second_id", 64'(want.high_id), 64'(second_id));
          check_field("found", 64'(want.found), 64'(found));
        end
      end
      // Point side: store the point, and on the closing point predict the set's result.
      if (in_valid && !in_stall) begin
        if (set_size < DEPTH) begin
          set_x[set_size]  = x_coord;
          set_y[set_size]  = y_coord;
          set_id[set_size] = point_id;
          set_size++;
        end
        if (last_point) begin
          closest_q.push_back(closest_in_set());
          set_size = 0;
        end
      end
    end
    open_results   <= closest_q.size();
    mismatch_count <= errors;
  end

endmodule

FILE: test/tb_closest_pair_of_points_top.sv
// Testbench top for the closest-pair block: clock, reset, point stimulus, result taker and verdict.
module tb_closest_pair_of_points_top;
  timeunit 1ns;
  timeprecision 1ps;

  // A small store keeps full-store scans short while still reaching the overflow case.
  localparam int STORE_DEPTH   = 64;
  localparam int POINT_TARGET  = 1150;
  localparam int MAX_IDLE      = 13;
  localparam int LONG_HOLD     = 3000;
  localparam int SETTLE_CYCLES = 200;

  localparam logic signed [cpp_pkg::COORD_W-1:0] COORD_MIN =
    {1'b1, {(cpp_pkg::COORD_W-1){1'b0}}};
  localparam logic signed [cpp_pkg::COORD_W-1:0] COORD_MAX =
    {1'b0, {(cpp_pkg::COORD_W-1){1'b1}}};
  localparam logic [cpp_pkg::ID_W-1:0]           ID_MAX    = '1;

  typedef enum int {SPREAD, CLUSTER, EDGES} coord_mode_t;

  logic                               clk;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic signed [cpp_pkg::COORD_W-1:0] x_coord = '0;
  logic signed [cpp_pkg::COORD_W-1:0] y_coord = '0;
  logic [cpp_pkg::ID_W-1:0]           point_id = '0;
  logic                               last_point = 1'b0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic [cpp_pkg::DIST_W-1:0]         min_dist_sq;
  logic [cpp_pkg::ID_W-1:0]           first_id;
  logic [cpp_pkg::ID_W-1:0]           second_id;
  logic                               found;
  int                                 mismatch_count;
  int                                 open_results;

  int points_loaded = 0;
  int results_taken = 0;
  bit send_burst = 1'b0;
  bit take_burst = 1'b0;

  closest_pair_of_points_top #(.MAX_POINTS(STORE_DEPTH)) uut (.*);

  closest_pair_monitor #(.DEPTH(STORE_DEPTH)) pair_monitor (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #20_000_000;
    $display("tb_closest_pair_of_points_top: FAIL");
    $finish;
  end

  // Offer one point after a random gap (none while send_burst is set) and hold it until the block takes it.
  task automatic send_point(input logic signed [cpp_pkg::COORD_W-1:0] px,
                            input logic signed [cpp_pkg::COORD_W-1:0] py,
                            input logic [cpp_pkg::ID_W-1:0] pid, input logic is_last);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    x_coord    <= px;
    y_coord    <= py;
    point_id   <= pid;
    last_point <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Pause the point stream until every predicted result has been taken.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (open_results != 0);
  endtask

  function automatic logic signed [cpp_pkg::COORD_W-1:0] pick_coord(
    input coord_mode_t mode, input logic signed [cpp_pkg::COORD_W-1:0] center);
    case (mode)
      SPREAD:  return cpp_pkg::COORD_W'($urandom());
      CLUSTER: return center + cpp_pkg::COORD_W'($urandom_range(0, 3));
      default: begin
        case ($urandom_range(0, 3))
          0:       return COORD_MIN;
          1:       return COORD_MAX;
          2:       return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  // One point set: clustered sets and narrow ids make distance ties and shared ids common.
  task automatic send_set(input int size);
    coord_mode_t                        mode;
    logic signed [cpp_pkg::COORD_W-1:0] cx;
    logic signed [cpp_pkg::COORD_W-1:0] cy;
    bit                                 narrow_ids;
    int                                 pick;
    pick       = $urandom_range(0, 99);
    mode       = (pick < 40) ? SPREAD : (pick < 85) ? CLUSTER : EDGES;
    cx         = cpp_pkg::COORD_W'($urandom());
    cy         = cpp_pkg::COORD_W'($urandom());
    narrow_ids = $urandom_range(0, 1);
    for (int k = 0; k < size; k++) begin
      send_point(pick_coord(mode, cx), pick_coord(mode, cy),
                 narrow_ids ? cpp_pkg::ID_W'($urandom_range(0, 7)) :
                              cpp_pkg::ID_W'($urandom_range(0, ID_MAX)),
                 k == size - 1);
      if (k < STORE_DEPTH) points_loaded++;
    end
  endtask

  // Point stimulus and verdict.
  initial begin
    int set_count;
    int size;
    int pick;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // A lone point: no pair exists.
    send_point(COORD_MAX, COORD_MIN, ID_MAX, 1'b1);
    // Opposite corners give the largest distance; ids arrive high first.
    send_point(COORD_MIN, COORD_MIN, ID_MAX, 1'b0);
    send_point(COORD_MAX, COORD_MAX, 0, 1'b1);
    // Identical points sharing one id.
    send_point(-7, 12, 300, 1'b0);
    send_point(-7, 12, 300, 1'b1);
    // Three pairs tie at distance one; the smallest id pair must win.
    send_point(0, 0, 5, 1'b0);
    send_point(1, 0, 3, 1'b0);
    send_point(2, 0, 9, 1'b0);
    send_point(0, 1, 4, 1'b1);
    // Points on both sides of zero, with extreme ids.
    send_point(-1, -1, 0, 1'b0);
    send_point(0, 0, ID_MAX, 1'b0);
    send_point(COORD_MAX, COORD_MIN, 512, 1'b1);
    // Full horizontal span on one row.
    send_point(COORD_MIN, 5, 7, 1'b0);
    send_point(COORD_MAX, 5, 8, 1'b1);
    // Everything zero.
    send_point(0, 0, 0, 1'b0);
    send_point(0, 0, 0, 1'b0);
    send_point(0, 0, 0, 1'b1);
    wait_for_results();

    // Random sets, mostly small; a few fill the store exactly or overflow it.
    set_count = 0;
    while (points_loaded < POINT_TARGET) begin
      if (set_count == 30) begin
        size = STORE_DEPTH;
      end else if (set_count == 60 || set_count == 90) begin
        size = STORE_DEPTH + $urandom_range(1, 3);
      end else begin
        pick = $urandom_range(0, 99);
        size = (pick < 75) ? $urandom_range(1, 8) :
               (pick < 95) ? $urandom_range(9, 24) : $urandom_range(25, STORE_DEPTH);
      end
      if ($urandom_range(0, 7) == 0) send_burst = !send_burst;
      send_set(size);
      set_count++;
      if (set_count % 25 == 0) wait_for_results();
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_closest_pair_of_points_top: PASS");
    end else begin
      $display("tb_closest_pair_of_points_top: FAIL");
    end
    $finish;
  end

  // Result taker: random stalls, stall-free stretches and one long hold-off.
  initial begin
    int hold;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (results_taken == 20) begin
        hold = LONG_HOLD;
      end else begin
        if ($urandom_range(0, 5) == 0) take_burst = !take_burst;
        hold = take_burst ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_taken++;
    end
  end

endmodule
